FILE: rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Word layouts for the input and result channels, operation and status codes,
// and the control bundle broadcast to every storage cell.
// ---------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int LEN_W  = 5;

    // operation codes
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } t_op;

    // status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef struct packed {
        t_op   op;
        t_word value;
    } t_in_word;

    typedef struct packed {
        t_word            popped_value;
        t_status          status;
        logic [LEN_W-1:0] length;
        t_word            front_value;
        t_word            rear_value;
    } t_out_word;

    // per-cycle command seen by every cell, at most one member set
    typedef struct packed {
        logic shift_back;   // push front: every cell takes its front neighbor
        logic append;       // push rear: first empty cell takes the new word
        logic shift_fwd;    // pop front: every cell takes its rear neighbor
        logic trim;         // pop rear: last occupied cell is released
    } t_cell_ctrl;

endpackage

FILE: rtl/deq_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deq_cell: one storage slot of the queue chain
// Holds one word and its occupied flag, and moves data to or from its
// neighbors according to the broadcast command.
// ---------------------------------------------------------------------------
module deq_cell
    import deq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_word      i_value,
    input  t_word      i_left_data,
    input  logic       i_left_valid,
    input  t_word      i_right_data,
    input  logic       i_right_valid,
    output t_word      o_data,
    output logic       o_valid,
    output t_word      o_next_data,
    output logic       o_next_valid
);

    t_word r_data;
    logic  r_valid;
    t_word n_data;
    logic  n_valid;

    // next contents from the command and the neighbors
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        priority if (i_ctrl.shift_back) begin
            n_data  = i_left_data;
            n_valid = i_left_valid;
        end else if (i_ctrl.append && !r_valid && i_left_valid) begin
            n_data  = i_value;
            n_valid = 1'b1;
        end else if (i_ctrl.shift_fwd) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end else if (i_ctrl.trim && r_valid && !i_right_valid) begin
            n_valid = 1'b0;
        end else begin
            // no command for this cell: hold
            n_data  = r_data;
            n_valid = r_valid;
        end
    end

    // occupied flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // stored word
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data       = r_data;
    assign o_valid      = r_valid;
    assign o_next_data  = n_data;
    assign o_next_valid = n_valid;

endmodule

FILE: rtl/double_ended_queue_unit.sv
`timescale 1ns / 1ps
// a result word is registered in the result register when its input word is accepted
// throughput: one word per cycle while intake is not stalled; every operation is a single step of the cell chain
// the result register stalls intake only while it holds a word not yet taken
// reset (synchronous, active low) empties the queue and drops any pending result
// stored words carry no reset; only the occupied flags, the length counter and the result valid flag are cleared
// ---------------------------------------------------------------------------
// double_ended_queue_unit: double-ended queue built as a chain of cells
// The front word lives in cell 0 and the words fill the chain toward the
// last cell; pushes and pops at the front shift the whole chain by one.
// ---------------------------------------------------------------------------
module double_ended_queue_unit
    import deq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    t_word            w_data      [DEPTH];
    t_word            w_next_data [DEPTH];
    logic [DEPTH-1:0] w_valid;
    logic [DEPTH-1:0] w_next_valid;
    t_cell_ctrl       w_ctrl;

    logic [LEN_W-1:0] r_count;
    logic [LEN_W-1:0] n_count;
    logic             r_out_valid;
    t_out_word        r_out_word;
    t_out_word        n_out_word;

    logic  w_accept;
    logic  w_is_push;
    logic  w_full;
    logic  w_empty;
    t_word w_rear_now;
    t_word w_rear_next;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_is_push  = (i_in_word.op == OP_PUSH_FRONT) || (i_in_word.op == OP_PUSH_REAR);
    assign w_full     = (r_count == LEN_W'(DEPTH));
    assign w_empty    = (r_count == '0);

    // command broadcast to the chain
    always_comb begin
        w_ctrl = '0;
        if (w_accept) begin
            unique case (i_in_word.op)
                OP_PUSH_FRONT: w_ctrl.shift_back = !w_full;
                OP_PUSH_REAR:  w_ctrl.append     = !w_full;
                OP_POP_FRONT:  w_ctrl.shift_fwd  = !w_empty;
                OP_POP_REAR:   w_ctrl.trim       = !w_empty;
                default:       w_ctrl = '0;
            endcase
        end
    end

    // cell chain; cell 0 sees the new word as its front neighbor
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word w_left_data;
        logic  w_left_valid;
        t_word w_right_data;
        logic  w_right_valid;

        if (g == 0) begin : g_first
            assign w_left_data  = i_in_word.value;
            assign w_left_valid = 1'b1;
        end else begin : g_mid
            assign w_left_data  = w_data[g-1];
            assign w_left_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_data  = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right_data  = w_data[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        deq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_value      (i_in_word.value),
            .i_left_data  (w_left_data),
            .i_left_valid (w_left_valid),
            .i_right_data (w_right_data),
            .i_right_valid(w_right_valid),
            .o_data       (w_data[g]),
            .o_valid      (w_valid[g]),
            .o_next_data  (w_next_data[g]),
            .o_next_valid (w_next_valid[g])
        );
    end

    // rear word before and after the step: the last occupied cell
    always_comb begin
        w_rear_now  = '0;
        w_rear_next = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_valid[i] && (i == DEPTH - 1 || !w_valid[(i + 1) % DEPTH])) begin
                w_rear_now = w_rear_now | w_data[i];
            end
            if (w_next_valid[i] && (i == DEPTH - 1 || !w_next_valid[(i + 1) % DEPTH])) begin
                w_rear_next = w_rear_next | w_next_data[i];
            end
        end
    end

    // length update and result word
    always_comb begin
        n_count                 = r_count;
        n_out_word              = '0;
        n_out_word.status       = ST_OK;
        if (w_is_push) begin
            if (w_full) begin
                n_out_word.status = ST_FULL;
            end else begin
                n_count = r_count + LEN_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_out_word.status = ST_EMPTY;
            end else begin
                n_count = r_count - LEN_W'(1);
                n_out_word.popped_value = (i_in_word.op == OP_POP_FRONT) ? w_data[0]
                                                                         : w_rear_now;
            end
        end
        n_out_word.length      = n_count;
        n_out_word.front_value = w_next_valid[0] ? w_next_data[0] : '0;
        n_out_word.rear_value  = w_rear_next;
    end

    // length counter and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (o_in_ready) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // occupied flags always match the length counter
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("occupied cells disagree with length");

    // when the last cell is occupied, every cell is occupied
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[DEPTH-1] |-> (w_valid == {DEPTH{1'b1}}))
        else $error("gap in occupied cells");

    // push on a full queue reports full and keeps the length
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_push && w_full) |=>
            (o_out_word.status == ST_FULL) && (r_count == LEN_W'(DEPTH)))
        else $error("push on full queue not rejected");

    // pop on an empty queue reports empty with a zero word
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_push && w_empty) |=>
            (o_out_word.status == ST_EMPTY) && (o_out_word.popped_value == '0))
        else $error("pop on empty queue not reported");

endmodule

FILE: tb/sv/tb_double_ended_queue_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_double_ended_queue_unit: self-checking bench for the double-ended queue
// A queue of pending words feeds a clocked driver. A clocked monitor predicts
// each accepted operation on its own deque model and compares every result
// word, field by field, in order. Both sides insert random gaps and stalls.
// ---------------------------------------------------------------------------
module tb_double_ended_queue_unit;
    import deq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1260;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 40;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_word  in_word    = '0;
    logic      out_ready  = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_word;

    t_in_word  pending_words[$];
    t_out_word expected_results[$];
    t_word     deque_contents[$];

    logic in_fire     = 1'b0;
    int   gap_left    = 0;
    int   stall_left  = 0;
    int   send_calm   = 0;
    int   recv_calm   = 0;
    int   cycle_count = 0;
    int   error_count = 0;

    double_ended_queue_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // gap length: mostly none or short, a few long, now and then a calm stretch
    function automatic int pick_gap(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(30, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 9);
        return $urandom_range(15, 40);
    endfunction

    // word values with extra weight on the extremes
    function automatic t_word pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 32'sh7fff_ffff;
        if (r < 16) return 32'sh8000_0000;
        if (r < 21) return '0;
        if (r < 26) return '1;
        return t_word'($urandom());
    endfunction

    function automatic t_in_word make_word(input t_op op, input t_word value);
        t_in_word w;
        w.op    = op;
        w.value = value;
        return w;
    endfunction

    // apply one operation to the deque model and build its result word
    function automatic t_out_word apply_deque_op(input t_in_word w);
        t_out_word r;
        r = '0;
        r.status = ST_OK;
        case (w.op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (deque_contents.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (w.op == OP_PUSH_FRONT) begin
                    deque_contents.push_front(w.value);
                end else begin
                    deque_contents.push_back(w.value);
                end
            end
            default: begin
                if (deque_contents.size() == 0) begin
                    r.status = ST_EMPTY;
                end else if (w.op == OP_POP_FRONT) begin
                    r.popped_value = deque_contents.pop_front();
                end else begin
                    r.popped_value = deque_contents.pop_back();
                end
            end
        endcase
        r.length = LEN_W'(deque_contents.size());
        if (deque_contents.size() > 0) begin
            r.front_value = deque_contents[0];
            r.rear_value  = deque_contents[$];
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (actual !== expected) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, name, expected, actual);
            end
        end
    endtask

    // driver: present the next pending word after its gap, hold until taken
    always @(negedge i_clk) begin
        int g;
        if (i_rst_n) begin
            if (in_valid && !in_fire) begin
                // still waiting for acceptance
            end else if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_words.size() > 0) begin
                g = pick_gap(send_calm);
                in_word  <= pending_words.pop_front();
                in_valid <= 1'b1;
                gap_left <= g;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls on the result channel
    always @(negedge i_clk) begin
        int g;
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            g = ($urandom_range(0, 3) == 0) ? pick_gap(recv_calm) : 0;
            out_ready  <= 1'b1;
            stall_left <= g;
        end
    end

    // monitor: predict on input handshake, compare on result handshake
    always @(posedge i_clk) begin
        t_out_word exp_w;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            in_fire <= i_rst_n && in_valid && in_ready;
            if (i_rst_n && in_valid && in_ready) begin
                expected_results.push_back(apply_deque_op(in_word));
            end
            if (i_rst_n && out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: result word, expected none, actual %h",
                                 $time, out_word);
                    end
                end else begin
                    exp_w = expected_results.pop_front();
                    check_field("popped_value", exp_w.popped_value, out_word.popped_value);
                    check_field("status", exp_w.status, out_word.status);
                    check_field("length", exp_w.length, out_word.length);
                    check_field("front_value", exp_w.front_value, out_word.front_value);
                    check_field("rear_value", exp_w.rear_value, out_word.rear_value);
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int   seg_left;
        int   push_pct;
        int   r;
        t_op  op;
        seg_left = 0;
        push_pct = 50;

        // pops on the empty queue, then fill past full and drain past empty
        pending_words.push_back(make_word(OP_POP_FRONT, pick_value()));
        pending_words.push_back(make_word(OP_POP_REAR, pick_value()));
        for (int k = 0; k < DEPTH + 2; k++) begin
            op = (k % 2 == 0) ? OP_PUSH_REAR : OP_PUSH_FRONT;
            pending_words.push_back(make_word(op, pick_value()));
        end
        for (int k = 0; k < DEPTH + 2; k++) begin
            op = (k % 2 == 0) ? OP_POP_FRONT : OP_POP_REAR;
            pending_words.push_back(make_word(op, pick_value()));
        end

        // random segments leaning toward pushes, pops or neither
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(5, 40);
                r = $urandom_range(0, 2);
                push_pct = (r == 0) ? 85 : ((r == 1) ? 15 : 50);
            end
            seg_left--;
            if ($urandom_range(0, 99) < push_pct) begin
                op = ($urandom_range(0, 1) == 0) ? OP_PUSH_FRONT : OP_PUSH_REAR;
            end else begin
                op = ($urandom_range(0, 1) == 0) ? OP_POP_FRONT : OP_POP_REAR;
            end
            pending_words.push_back(make_word(op, pick_value()));
        end

        // hold reset, then release it at a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // wait until every word has been sent and every result checked
        do begin
            @(posedge i_clk);
            #2;
        end while (pending_words.size() > 0 || in_valid || expected_results.size() > 0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        #2;
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/double_ended_queue_unit.sv
tb/sv/tb_double_ended_queue_unit.sv
